[rtl/ptx_pkg.sv]
// Package with the item types, register codes and frame helpers of the parallel UART transmitter.
`default_nettype none
package ptx_pkg;

	localparam int LANE_FIELDS = 8;
	localparam int DEFAULT_LANES = 8;
	localparam int DEFAULT_DIVISOR_BITS = 16;

	localparam logic [15:0] BAUD_DIVISOR_RESET = 16'd1302;
	localparam logic [7:0] LANE_ENABLE_RESET = 8'hFF;
	localparam logic [7:0] IDLE_LEVELS = 8'hFF;

	localparam logic [3:0] START_SLOT = 4'd0;
	localparam logic [3:0] STOP_SLOT = 4'd9;

	localparam logic REG_BAUD_DIVISOR = 1'b0;
	localparam logic REG_LANE_ENABLE = 1'b1;

	typedef struct packed {
		logic [7:0] lane_byte_0;
		logic [7:0] lane_byte_1;
		logic [7:0] lane_byte_2;
		logic [7:0] lane_byte_3;
		logic [7:0] lane_byte_4;
		logic [7:0] lane_byte_5;
		logic [7:0] lane_byte_6;
		logic [7:0] lane_byte_7;
	} in_item_t;

	typedef struct packed {
		logic [7:0] line_levels;
		logic [7:0] line_toggles;
		logic [3:0] bit_slot;
		logic frame_last;
	} out_item_t;

	// Line level of one lane in a slot: start bit low, data LSB first, stop bit high.
	function automatic logic frame_bit(input logic [7:0] data, input logic [3:0] slot);
		logic [2:0] idx;
		logic bit_val;
		idx = 3'(slot - 4'd1);
		if (slot == START_SLOT) begin
			bit_val = 1'b0;
		end else if (slot >= STOP_SLOT) begin
			bit_val = 1'b1;
		end else begin
			bit_val = data[idx];
		end
		return bit_val;
	endfunction

endpackage
`default_nettype wire

[rtl/ptx_front.sv]
// Front end: accepts items, tags the enabled lanes and queues up to two frames.
`default_nettype none
module ptx_front #(
	parameter int LANES = ptx_pkg::DEFAULT_LANES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire ptx_pkg::in_item_t tx_bytes,
	input  wire logic [7:0] lane_enable,
	output logic frame_valid,
	input  wire logic frame_take,
	output logic [((LANES < 8) ? LANES : 8)-1:0][7:0] frame_bytes,
	output logic [((LANES < 8) ? LANES : 8)-1:0] frame_act
);
	import ptx_pkg::*;

	localparam int ACTIVE_LANES = (LANES < LANE_FIELDS) ? LANES : LANE_FIELDS;

	logic [LANE_FIELDS-1:0][7:0] lane_bytes;
	logic [ACTIVE_LANES-1:0][7:0] mem_bytes_q [2];
	logic [ACTIVE_LANES-1:0] mem_act_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic wr;
	logic rd;

	assign lane_bytes[0] = tx_bytes.lane_byte_0;
	assign lane_bytes[1] = tx_bytes.lane_byte_1;
	assign lane_bytes[2] = tx_bytes.lane_byte_2;
	assign lane_bytes[3] = tx_bytes.lane_byte_3;
	assign lane_bytes[4] = tx_bytes.lane_byte_4;
	assign lane_bytes[5] = tx_bytes.lane_byte_5;
	assign lane_bytes[6] = tx_bytes.lane_byte_6;
	assign lane_bytes[7] = tx_bytes.lane_byte_7;

	assign full = (count_q == 2'd2);
	assign frame_valid = (count_q != 2'd0);
	assign wr = push && !full;
	assign rd = frame_take && frame_valid;

	assign frame_bytes = mem_bytes_q[rd_ptr_q];
	assign frame_act = mem_act_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_bytes_q[wr_ptr_q] <= lane_bytes[ACTIVE_LANES-1:0];
			mem_act_q[wr_ptr_q] <= lane_enable[ACTIVE_LANES-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr, rd})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/ptx_back.sv]
// Back end: steps a frame through its ten baud slots and holds each slot's item for the reader.
`default_nettype none
module ptx_back #(
	parameter int LANES = ptx_pkg::DEFAULT_LANES,
	parameter int DIVISOR_BITS = ptx_pkg::DEFAULT_DIVISOR_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [DIVISOR_BITS-1:0] baud_divisor,
	input  wire logic frame_valid,
	output logic frame_take,
	input  wire logic [((LANES < 8) ? LANES : 8)-1:0][7:0] frame_bytes,
	input  wire logic [((LANES < 8) ? LANES : 8)-1:0] frame_act,
	output logic empty,
	input  wire logic pop,
	output ptx_pkg::out_item_t tx_slot
);
	import ptx_pkg::*;

	localparam int ACTIVE_LANES = (LANES < LANE_FIELDS) ? LANES : LANE_FIELDS;

	logic busy_q;
	logic [3:0] slot_q;
	logic [DIVISOR_BITS-1:0] cnt_q;
	logic [7:0] prev_q;
	logic [ACTIVE_LANES-1:0][7:0] bytes_q;
	logic [ACTIVE_LANES-1:0] act_q;
	logic out_valid_q;
	out_item_t out_q;
	logic [7:0] levels;
	logic emit;

	genvar g;
	generate
		for (g = 0; g < LANE_FIELDS; g++) begin : g_lane
			if (g < ACTIVE_LANES) begin : g_act
				assign levels[g] = !act_q[g] || frame_bit(bytes_q[g], slot_q);
			end else begin : g_idle
				assign levels[g] = 1'b1;
			end
		end
	endgenerate

	assign frame_take = !busy_q && frame_valid;
	assign emit = busy_q && (cnt_q >= baud_divisor) && (!out_valid_q || pop);
	assign empty = !out_valid_q;
	assign tx_slot = out_q;

	always_ff @(posedge clk) begin
		if (frame_take) begin
			bytes_q <= frame_bytes;
			act_q <= frame_act;
		end
		if (emit) begin
			out_q.line_levels <= levels;
			out_q.line_toggles <= levels ^ prev_q;
			out_q.bit_slot <= slot_q;
			out_q.frame_last <= (slot_q == STOP_SLOT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			slot_q <= START_SLOT;
			cnt_q <= '0;
			prev_q <= IDLE_LEVELS;
			out_valid_q <= 1'b0;
		end else begin
			if (frame_take) begin
				busy_q <= 1'b1;
				slot_q <= START_SLOT;
				cnt_q <= DIVISOR_BITS'(1);
				prev_q <= IDLE_LEVELS;
			end else if (emit) begin
				slot_q <= slot_q + 4'd1;
				cnt_q <= DIVISOR_BITS'(1);
				prev_q <= levels;
				if (slot_q == STOP_SLOT) begin
					busy_q <= 1'b0;
				end
			end else if (busy_q && (cnt_q < baud_divisor)) begin
				cnt_q <= cnt_q + DIVISOR_BITS'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/parallel_uart_transmitter_top.sv]
// Top level of the parallel UART transmitter: configuration registers, front end and back end.
//
// Each accepted item is one byte per lane, sent on all lanes together as an 8N1 frame and
// returned as ten items, one per baud slot (start bit, eight data bits LSB first, stop bit).
// A slot item becomes available once its slot timer has reached baud_divisor (a divisor of
// zero acts as one) and the held slot item is gone or is being popped. A two-frame queue
// ahead of the slot sequencer lets new items be taken while a frame is still being sent.
// Lanes at or above LANES, and lanes whose lane_enable bit is clear, stay high. Registers
// are to be written only while idle, by the user; the block itself does not enforce this.
`default_nettype none
module parallel_uart_transmitter_top #(
	parameter int LANES = ptx_pkg::DEFAULT_LANES,
	parameter int DIVISOR_BITS = ptx_pkg::DEFAULT_DIVISOR_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire ptx_pkg::in_item_t tx_bytes,
	output logic empty,
	input  wire logic pop,
	output ptx_pkg::out_item_t tx_slot,
	input  wire logic wr_en,
	input  wire logic wr_index,
	input  wire logic [DIVISOR_BITS-1:0] wr_data
);
	import ptx_pkg::*;

	localparam int ACTIVE_LANES = (LANES < LANE_FIELDS) ? LANES : LANE_FIELDS;

	logic [DIVISOR_BITS-1:0] baud_divisor_q;
	logic [7:0] lane_enable_q;
	logic frame_valid;
	logic frame_take;
	logic [ACTIVE_LANES-1:0][7:0] frame_bytes;
	logic [ACTIVE_LANES-1:0] frame_act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baud_divisor_q <= DIVISOR_BITS'(BAUD_DIVISOR_RESET);
			lane_enable_q <= LANE_ENABLE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_BAUD_DIVISOR: baud_divisor_q <= wr_data;
				REG_LANE_ENABLE: lane_enable_q <= wr_data[7:0];
				default: lane_enable_q <= lane_enable_q;
			endcase
		end
	end

	ptx_front #(
		.LANES(LANES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.tx_bytes(tx_bytes),
		.lane_enable(lane_enable_q),
		.frame_valid(frame_valid),
		.frame_take(frame_take),
		.frame_bytes(frame_bytes),
		.frame_act(frame_act)
	);

	ptx_back #(
		.LANES(LANES),
		.DIVISOR_BITS(DIVISOR_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.baud_divisor(baud_divisor_q),
		.frame_valid(frame_valid),
		.frame_take(frame_take),
		.frame_bytes(frame_bytes),
		.frame_act(frame_act),
		.empty(empty),
		.pop(pop),
		.tx_slot(tx_slot)
	);

	a_last_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (tx_slot.frame_last == (tx_slot.bit_slot == STOP_SLOT)))
		else $error("frame_last does not match the stop slot");

	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && tx_slot.bit_slot == START_SLOT)
			|-> ((tx_slot.line_levels ^ tx_slot.line_toggles) == IDLE_LEVELS))
		else $error("start slot toggles are not taken from idle high lines");

	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && tx_slot.frame_last) |-> (tx_slot.line_levels == IDLE_LEVELS))
		else $error("stop slot leaves a line low");

endmodule
`default_nettype wire

[tb/parallel_uart_transmitter_top_test.sv]
// Testbench for the parallel UART transmitter: directed and random frames checked slot by slot.
`default_nettype none
module parallel_uart_transmitter_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ptx_pkg::*;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_item_t tx_bytes;
	logic empty;
	logic pop = 1'b0;
	out_item_t tx_slot;
	logic wr_en;
	logic wr_index;
	logic [15:0] wr_data;

	logic [7:0] lane_enable_cfg;
	out_item_t expected_slots[$];
	int send_idle_pct;
	int pop_stall_pct;
	int errors = 0;

	parallel_uart_transmitter_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.tx_bytes(tx_bytes),
		.empty(empty),
		.pop(pop),
		.tx_slot(tx_slot),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("FAIL parallel_uart_transmitter_top");
		$finish;
	end

	// Builds the ten slot items of one frame from the bytes and the lane enables.
	function automatic void predict_slots(input in_item_t it);
		logic [7:0] lane_data [8];
		logic [7:0] levels;
		logic [7:0] prev_levels;
		out_item_t slot_item;
		lane_data[0] = it.lane_byte_0;
		lane_data[1] = it.lane_byte_1;
		lane_data[2] = it.lane_byte_2;
		lane_data[3] = it.lane_byte_3;
		lane_data[4] = it.lane_byte_4;
		lane_data[5] = it.lane_byte_5;
		lane_data[6] = it.lane_byte_6;
		lane_data[7] = it.lane_byte_7;
		prev_levels = IDLE_LEVELS;
		for (int slot = START_SLOT; slot <= STOP_SLOT; slot++) begin
			levels = IDLE_LEVELS;
			for (int lane = 0; lane < LANE_FIELDS; lane++) begin
				if (lane_enable_cfg[lane]) begin
					if (slot == START_SLOT) begin
						levels[lane] = 1'b0;
					end else if (slot < STOP_SLOT) begin
						levels[lane] = lane_data[lane][slot - 1];
					end
				end
			end
			slot_item.line_levels = levels;
			slot_item.line_toggles = levels ^ prev_levels;
			slot_item.bit_slot = 4'(slot);
			slot_item.frame_last = (slot == STOP_SLOT);
			expected_slots.push_back(slot_item);
			prev_levels = levels;
		end
	endfunction

	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (expected_slots.size() == 0) begin
				$error("slot item with nothing expected: %p", tx_slot);
				errors++;
			end else begin
				want = expected_slots.pop_front();
				if (tx_slot.line_levels !== want.line_levels) begin
					$error("line_levels expected %h actual %h", want.line_levels,
						tx_slot.line_levels);
					errors++;
				end
				if (tx_slot.line_toggles !== want.line_toggles) begin
					$error("line_toggles expected %h actual %h", want.line_toggles,
						tx_slot.line_toggles);
					errors++;
				end
				if (tx_slot.bit_slot !== want.bit_slot) begin
					$error("bit_slot expected %0d actual %0d", want.bit_slot,
						tx_slot.bit_slot);
					errors++;
				end
				if (tx_slot.frame_last !== want.frame_last) begin
					$error("frame_last expected %b actual %b", want.frame_last,
						tx_slot.frame_last);
					errors++;
				end
			end
		end
	end

	task automatic send_item(input in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		tx_bytes <= it;
		do @(posedge clk); while (full);
		predict_slots(it);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (expected_slots.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [15:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= index;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		if (index == REG_LANE_ENABLE) begin
			lane_enable_cfg = data[7:0];
		end
	endtask

	task automatic set_idling(input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		pop_stall_pct = stall_pct;
	endtask

	function automatic in_item_t random_item();
		in_item_t it;
		it = in_item_t'({$urandom, $urandom});
		case ($urandom_range(9))
			0: it = '0;
			1: it = '1;
			2: it.lane_byte_3 = 8'h00;
			3: it.lane_byte_6 = 8'hFF;
			default: ;
		endcase
		return it;
	endfunction

	// Frames sent with the register values left by reset.
	task automatic test_reset_values();
		set_idling(0, 0);
		send_item(in_item_t'(64'h00FF_00FF_00FF_00FF));
		send_item(in_item_t'(64'hA55A_3CC3_0180_7E81));
		wait_drained();
	endtask

	task automatic test_byte_patterns();
		write_reg(REG_BAUD_DIVISOR, 16'd1);
		write_reg(REG_LANE_ENABLE, 16'h00FF);
		set_idling(0, 0);
		send_item(in_item_t'(64'h0000_0000_0000_0000));
		send_item(in_item_t'(64'hFFFF_FFFF_FFFF_FFFF));
		send_item(in_item_t'(64'h55AA_55AA_55AA_55AA));
		send_item(in_item_t'(64'h0102_0408_1020_4080));
		send_item(in_item_t'(64'h8040_2010_0804_0201));
		send_item(in_item_t'(64'h0180_0180_0180_0180));
		send_item(in_item_t'(64'hFE7F_FE7F_EF7F_F7FB));
		send_item(in_item_t'(64'h0011_2233_4455_6677));
		wait_drained();
	endtask

	// Disabled lanes must rest high; upper write data bits are ignored for this register.
	task automatic test_lane_enable();
		set_idling(11, 11);
		write_reg(REG_LANE_ENABLE, {8'($urandom), 8'h00});
		send_item(in_item_t'(64'h0000_0000_0000_0000));
		wait_drained();
		write_reg(REG_LANE_ENABLE, {8'($urandom), 8'h01});
		send_item(random_item());
		wait_drained();
		write_reg(REG_LANE_ENABLE, {8'($urandom), 8'h80});
		send_item(in_item_t'(64'h0000_0000_0000_0000));
		wait_drained();
		write_reg(REG_LANE_ENABLE, 16'hFF5A);
		send_item(random_item());
		wait_drained();
	endtask

	task automatic test_divisor_extremes();
		write_reg(REG_LANE_ENABLE, 16'h00FF);
		set_idling(0, 0);
		write_reg(REG_BAUD_DIVISOR, 16'd0);
		send_item(random_item());
		send_item(random_item());
		wait_drained();
		write_reg(REG_BAUD_DIVISOR, 16'hFFFF);
		send_item(random_item());
		wait_drained();
		write_reg(REG_BAUD_DIVISOR, 16'd2);
		set_idling(0, 77);
		send_item(random_item());
		send_item(random_item());
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int idle_pcts [4];
		int stall_pcts [4];
		idle_pcts = '{0, 77, 0, 11};
		stall_pcts = '{0, 0, 77, 11};
		for (int phase = 0; phase < 4; phase++) begin
			write_reg(REG_BAUD_DIVISOR, 16'($urandom_range(1, 4)));
			if (phase == 0) begin
				write_reg(REG_LANE_ENABLE, 16'h00FF);
			end else begin
				write_reg(REG_LANE_ENABLE, 16'($urandom));
			end
			set_idling(idle_pcts[phase], stall_pcts[phase]);
			for (int n = 0; n < 70; n++) begin
				send_item(random_item());
			end
			wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		tx_bytes = '0;
		wr_en = 1'b0;
		wr_index = REG_BAUD_DIVISOR;
		wr_data = '0;
		lane_enable_cfg = LANE_ENABLE_RESET;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_byte_patterns();
		test_lane_enable();
		test_divisor_extremes();
		test_random_traffic();

		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("PASS parallel_uart_transmitter_top");
		end else begin
			$display("FAIL parallel_uart_transmitter_top");
		end
		$finish;
	end

endmodule
`default_nettype wire
